// ===== src/integer_field_formatter_macros.svh =====
// Assertion macros for the integer field formatter.
// Included by the top level; no other dependencies.
`ifndef INTEGER_FIELD_FORMATTER_MACROS_SVH
`define INTEGER_FIELD_FORMATTER_MACROS_SVH
`ifndef ASSERT_OFF
`define IFF_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define IFF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define IFF_ASSERT(lbl, ck, rn, prop, msg)
`define IFF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// ===== src/iff_pkg.sv =====
// Shared constants and the digit character function of the integer field formatter.
// No dependencies.
package iff_pkg;
    localparam int MAX_DIGITS_DEF       = 64;
    localparam int VALUE_BITS_DEF       = 64;
    localparam int BYTES_PER_RESULT_DEF = 8;
    localparam int DIGIT_CAP            = 64;
    localparam int DIV_STEPS            = 8;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER = 8'h41 - 8'd10;
    localparam logic [7:0] CH_LOWER = 8'h61 - 8'd10;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    localparam logic [1:0] JUST_RIGHT  = 2'd2;
    localparam logic [1:0] JUST_CENTER = 2'd3;
    localparam logic [1:0] SIGN_PLUS   = 2'd1;
    localparam logic [1:0] SIGN_SPACE  = 2'd2;
    localparam logic [1:0] SIGN_NONE   = 2'd3;

    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic up);
        logic [7:0] dw;
        begin
            dw = {2'b00, d};
            if (d < 6'd10)
                digit_char = CH_ZERO + dw;
            else
                digit_char = dw + (up ? CH_UPPER : CH_LOWER);
        end
    endfunction
endpackage

// ===== src/iff_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/integer_field_formatter.sv =====
// Integer field formatter: printf-style integer conversion into packed characters.
// Depends on iff_pkg, iff_ram and integer_field_formatter_macros.svh.
//
// Usage: drive value and the field settings and raise start; the word is taken
// at the clock edge where start is high and busy is low. busy then stays high
// until the last result has been produced. Results appear on out_bytes,
// byte_count, total_chars and last for exactly one cycle each, marked by
// out_valid; the receiver cannot stall, so every result must be taken as it
// comes. One item gives ceil(total / BYTES_PER_RESULT) results, where total
// is the larger of min_width and the text length.
// Sequence: after the setup at acceptance, each digit is produced by the shared
// restoring divider (8 quotient bits a cycle), then come the length and padding
// states, then a fetch and a place state per emitted character, since each
// character is fetched from the digit RAM with a registered read. busy drops at
// the same edge that registers the last result, so it is already low while
// that result is on the ports.
// Reset clears the sequencer and the strobe; the digit RAM is not cleared,
// since every digit is written before it is read.
module integer_field_formatter #(
    parameter int MAX_DIGITS       = iff_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS       = iff_pkg::VALUE_BITS_DEF,
    parameter int BYTES_PER_RESULT = iff_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [VALUE_BITS-1:0]    value,
    input  logic [5:0]                      base,
    input  logic [6:0]                      min_digits,
    input  logic [7:0]                      max_width,
    input  logic [7:0]                      min_width,
    input  logic [1:0]                      justify,
    input  logic [1:0]                      sign_mode,
    input  logic                            upper_case,
    output logic                            out_valid,
    output logic [8*BYTES_PER_RESULT-1:0]   out_bytes,
    output logic [3:0]                      byte_count,
    output logic [7:0]                      total_chars,
    output logic                            last
);
    import iff_pkg::*;

    localparam int QW         = ((VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
    localparam int DIV_CYCLES = QW / DIV_STEPS;
    localparam int CW         = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int AW         = $clog2(DIGIT_CAP);
    localparam int OW         = 8 * BYTES_PER_RESULT;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_LEN, S_PAD, S_FETCH, S_PLACE} state_t;

    state_t          state_reg, state_next;
    logic [5:0]      base_reg, base_next;
    logic [6:0]      md_reg, md_next;
    logic [7:0]      maxd_reg, maxd_next;
    logic [7:0]      mw_reg, mw_next;
    logic [7:0]      minw_reg, minw_next;
    logic [1:0]      just_reg, just_next;
    logic            up_reg, up_next;
    logic [7:0]      sc_reg, sc_next;
    logic            lone_reg, lone_next;
    logic [QW-1:0]   dq_reg, dq_next;
    logic [5:0]      rem_reg, rem_next;
    logic [CW-1:0]   dcnt_reg, dcnt_next;
    logic [6:0]      n_reg, n_next;
    logic [7:0]      len_reg, len_next;
    logic            ovf_reg, ovf_next;
    logic [7:0]      lp_reg, lp_next;
    logic [7:0]      total_reg, total_next;
    logic [7:0]      p_reg, p_next;
    logic [3:0]      bcnt_reg, bcnt_next;
    logic [OW-1:0]   word_reg, word_next;
    logic [7:0]      char_reg, char_next;
    logic            from_ram_reg, from_ram_next;
    logic            ov_reg, ov_next;
    logic [OW-1:0]   ob_reg, ob_next;
    logic [3:0]      bc_reg, bc_next;
    logic [7:0]      tc_reg, tc_next;
    logic            last_reg, last_next;

    logic [VALUE_BITS-1:0] mag;
    logic [7:0]      sc_in;
    logic [6:0]      md_in;
    logic [7:0]      maxd_in;
    logic [6:0]      r;
    logic [QW-1:0]   d;
    logic [6:0]      n1;
    logic [7:0]      sw;
    logic [7:0]      len_c;
    logic [7:0]      pad;
    logic [7:0]      t;
    logic [8:0]      text_end;
    logic [7:0]      ridx;
    logic [7:0]      c;
    logic [7:0]      p1;
    logic [3:0]      b1;
    logic            ram_we;
    logic [7:0]      ram_rdata;

    iff_ram #(.WIDTH(8), .DEPTH(DIGIT_CAP)) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (n_reg[AW-1:0]),
        .wdata (digit_char(r[5:0], up_reg)),
        .raddr (ridx[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        base_next     = base_reg;
        md_next       = md_reg;
        maxd_next     = maxd_reg;
        mw_next       = mw_reg;
        minw_next     = minw_reg;
        just_next     = just_reg;
        up_next       = up_reg;
        sc_next       = sc_reg;
        lone_next     = lone_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        dcnt_next     = dcnt_reg;
        n_next        = n_reg;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        lp_next       = lp_reg;
        total_next    = total_reg;
        p_next        = p_reg;
        bcnt_next     = bcnt_reg;
        word_next     = word_reg;
        char_next     = char_reg;
        from_ram_next = from_ram_reg;
        ov_next       = 1'b0;
        ob_next       = ob_reg;
        bc_next       = bc_reg;
        tc_next       = tc_reg;
        last_next     = last_reg;
        ram_we        = 1'b0;

        mag = value;
        sc_in = 8'd0;
        if (sign_mode != SIGN_NONE && value[VALUE_BITS-1])
        begin
            sc_in = CH_MINUS;
            mag = -value;
        end
        else if (sign_mode == SIGN_PLUS)
        begin
            sc_in = CH_PLUS;
        end
        else if (sign_mode == SIGN_SPACE)
        begin
            sc_in = CH_SPACE;
        end
        md_in = (min_digits > 7'(MAX_DIGITS)) ? 7'(MAX_DIGITS) : min_digits;
        maxd_in = (max_width == 8'd0 || max_width > 8'(MAX_DIGITS)) ? 8'(MAX_DIGITS)
                                                                     : max_width;

        r = {1'b0, rem_reg};
        d = dq_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            r = {r[5:0], d[QW-1]};
            d = {d[QW-2:0], 1'b0};
            if (r >= {1'b0, base_reg})
            begin
                r = r - {1'b0, base_reg};
                d[0] = 1'b1;
            end
        end
        n1 = n_reg + 7'd1;

        sw = {7'd0, (sc_reg != 8'd0)};
        len_c = sw + {1'b0, n_reg};
        pad = (minw_reg > len_reg) ? minw_reg - len_reg : 8'd0;
        t = p_reg - lp_reg;
        text_end = {1'b0, lp_reg} + {1'b0, len_reg};
        ridx = {1'b0, n_reg} - 8'd1 - t + sw;
        c = from_ram_reg ? ram_rdata : char_reg;
        p1 = p_reg + 8'd1;
        b1 = bcnt_reg + 4'd1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    base_next = (base < 6'd2) ? 6'd2 : ((base > 6'd36) ? 6'd36 : base);
                    maxd_next = maxd_in;
                    mw_next   = max_width;
                    minw_next = min_width;
                    just_next = justify;
                    up_next   = upper_case;
                    sc_next   = sc_in;
                    md_next   = md_in;
                    lone_next = 1'b0;
                    if (sc_in != 8'd0 && {1'b0, md_in} == maxd_in)
                    begin
                        md_next   = md_in - 7'd1;
                        lone_next = (md_in == 7'd1);
                    end
                    dq_next   = QW'(mag);
                    rem_next  = 6'd0;
                    dcnt_next = '0;
                    n_next    = 7'd0;
                    state_next = (sc_in != 8'd0 && md_in == 7'd1 && maxd_in == 8'd1)
                                 ? S_LEN : S_DIV;
                end
            end
            S_DIV:
            begin
                dq_next  = d;
                rem_next = r[5:0];
                if (dcnt_reg == CW'(DIV_CYCLES - 1))
                begin
                    ram_we    = 1'b1;
                    n_next    = n1;
                    rem_next  = 6'd0;
                    dcnt_next = '0;
                    if (!((d != '0 || n1 < md_reg) && n1 < 7'(DIGIT_CAP)))
                    begin
                        state_next = S_LEN;
                    end
                end
                else
                begin
                    dcnt_next = dcnt_reg + CW'(1);
                end
            end
            S_LEN:
            begin
                ovf_next = len_c > maxd_reg;
                if (lone_reg)
                    len_next = 8'd1;
                else if (len_c > maxd_reg)
                    len_next = sw + maxd_reg;
                else
                    len_next = len_c;
                if (mw_reg != 8'd0 && len_next > mw_reg)
                    len_next = mw_reg;
                state_next = S_PAD;
            end
            S_PAD:
            begin
                priority if (just_reg == JUST_RIGHT)
                    lp_next = pad;
                else if (just_reg == JUST_CENTER)
                    lp_next = pad >> 1;
                else
                    lp_next = 8'd0;
                total_next = (minw_reg > len_reg) ? minw_reg : len_reg;
                p_next     = 8'd0;
                bcnt_next  = 4'd0;
                word_next  = '0;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                from_ram_next = 1'b0;
                priority if (p_reg < lp_reg || {1'b0, p_reg} >= text_end)
                    char_next = CH_SPACE;
                else if (lone_reg)
                    char_next = CH_HASH;
                else if (sc_reg != 8'd0 && t == 8'd0)
                    char_next = sc_reg;
                else if (ovf_reg)
                    char_next = CH_HASH;
                else
                    from_ram_next = 1'b1;
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                for (int k = 0; k < BYTES_PER_RESULT; k++)
                begin
                    if (bcnt_reg == 4'(k))
                        word_next[8*k +: 8] = c;
                end
                bcnt_next = b1;
                p_next    = p1;
                state_next = S_FETCH;
                if (b1 == 4'(BYTES_PER_RESULT) || p1 == total_reg)
                begin
                    ov_next   = 1'b1;
                    ob_next   = word_next;
                    bc_next   = b1;
                    tc_next   = p1;
                    last_next = (p1 == total_reg);
                    bcnt_next = 4'd0;
                    word_next = '0;
                    if (p1 == total_reg)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        md_reg       <= md_next;
        maxd_reg     <= maxd_next;
        mw_reg       <= mw_next;
        minw_reg     <= minw_next;
        just_reg     <= just_next;
        up_reg       <= up_next;
        sc_reg       <= sc_next;
        lone_reg     <= lone_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        n_reg        <= n_next;
        len_reg      <= len_next;
        ovf_reg      <= ovf_next;
        lp_reg       <= lp_next;
        total_reg    <= total_next;
        p_reg        <= p_next;
        bcnt_reg     <= bcnt_next;
        word_reg     <= word_next;
        char_reg     <= char_next;
        from_ram_reg <= from_ram_next;
        ob_reg       <= ob_next;
        bc_reg       <= bc_next;
        tc_reg       <= tc_next;
        last_reg     <= last_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign out_valid   = ov_reg;
    assign out_bytes   = ob_reg;
    assign byte_count  = bc_reg;
    assign total_chars = tc_reg;
    assign last        = last_reg;

`include "integer_field_formatter_macros.svh"

    `IFF_ASSERT(a_count_range, clk, rst_n, out_valid |-> (byte_count != 4'd0 && byte_count <= 4'(BYTES_PER_RESULT)), "byte count out of range")
    `IFF_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted word did not raise busy")
    `IFF_ASSERT(a_more_busy, clk, rst_n, (out_valid && !last) |-> busy, "sequencer idle before the last result")
    `IFF_ASSERT(a_last_total, clk, rst_n, (out_valid && last) |-> (total_chars == total_reg), "last result does not close the field")
endmodule

// ===== bench/integer_field_formatter_tb.sv =====
// Self-checking bench for integer_field_formatter: drives formatting requests
// and compares every emitted character word with a local formatting model.
// Depends on iff_pkg and the integer_field_formatter RTL.
module integer_field_formatter_tb;
    import iff_pkg::*;

    typedef struct packed {
        logic [63:0] value;
        logic [5:0]  base;
        logic [6:0]  min_digits;
        logic [7:0]  max_width;
        logic [7:0]  min_width;
        logic [1:0]  justify;
        logic [1:0]  sign_mode;
        logic        upper_case;
    } request_t;

    typedef struct packed {
        logic [63:0] chars;
        logic [3:0]  count;
        logic [7:0]  total;
        logic        last;
    } word_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        busy_at_edge;
    logic [63:0] value;
    logic [5:0]  base;
    logic [6:0]  min_digits;
    logic [7:0]  max_width;
    logic [7:0]  min_width;
    logic [1:0]  justify;
    logic [1:0]  sign_mode;
    logic        upper_case;
    logic        out_valid;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic [7:0]  total_chars;
    logic        last;

    request_t pending_requests[$];
    word_t    expected_words[$];
    int       failures;
    bit       all_sent;
    int       gap;

    integer_field_formatter dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .value(value),
        .base(base), .min_digits(min_digits), .max_width(max_width),
        .min_width(min_width), .justify(justify), .sign_mode(sign_mode),
        .upper_case(upper_case), .out_valid(out_valid), .out_bytes(out_bytes),
        .byte_count(byte_count), .total_chars(total_chars), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] to_digit(int d, logic up);
        if (d < 10)
            return CH_ZERO + 8'(d);
        return 8'(d) + (up ? CH_UPPER : CH_LOWER);
    endfunction

    task automatic format_request(input request_t r);
        int b, md, maxd, len, pad, lp, rp, total, n, width, pos, i, k;
        logic [7:0] sc;
        logic [7:0] text[65];
        logic [7:0] digits[64];
        logic [63:0] mag;
        logic [7:0] c;
        bit lone;
        word_t w;
        b = r.base;
        if (b < 2) b = 2;
        if (b > 36) b = 36;
        md = r.min_digits;
        if (md > 64) md = 64;
        maxd = (r.max_width == 0 || r.max_width > 64) ? 64 : r.max_width;
        sc = 8'd0;
        mag = r.value;
        if (r.sign_mode != SIGN_NONE) begin
            if (r.value[63]) begin
                sc = CH_MINUS;
                mag = -r.value;
            end else if (r.sign_mode == SIGN_PLUS)
                sc = CH_PLUS;
            else if (r.sign_mode == SIGN_SPACE)
                sc = CH_SPACE;
        end
        lone = 1'b0;
        if (sc != 0 && md == maxd)
        begin
            md--;
            if (md == 0)
                lone = 1'b1;
        end
        if (lone) begin
            text[0] = CH_HASH;
            len = 1;
        end else begin
            n = 0;
            pos = 0;
            do begin
                digits[n] = to_digit(int'(mag % 64'(b)), r.upper_case);
                n++;
                mag = mag / 64'(b);
            end while ((mag != 0 || n < md) && n < 64);
            width = (sc != 0) + n;
            if (sc != 0) begin
                text[pos] = sc;
                pos++;
            end
            if (width > maxd)
                for (k = 0; k < maxd; k++) begin
                    text[pos] = CH_HASH;
                    pos++;
                end
            else
                for (k = 0; k < n; k++) begin
                    text[pos] = digits[n - 1 - k];
                    pos++;
                end
            len = pos;
        end
        if (r.max_width != 0 && len > r.max_width)
            len = r.max_width;
        pad = (r.min_width > len) ? r.min_width - len : 0;
        lp = 0;
        rp = pad;
        if (r.justify == JUST_RIGHT) begin
            lp = pad;
            rp = 0;
        end else if (r.justify == JUST_CENTER) begin
            lp = pad / 2;
            rp = (pad + 1) / 2;
        end
        total = lp + len + rp;
        for (i = 0; i < total; i += 8) begin
            w = '0;
            for (k = 0; k < 8 && i + k < total; k++) begin
                c = (i + k < lp || i + k >= lp + len) ? CH_SPACE : text[i + k - lp];
                w.chars[8*k +: 8] = c;
                w.count++;
            end
            w.total = 8'(i + k);
            w.last = (i + k >= total);
            expected_words.push_back(w);
        end
    endtask

    function automatic request_t random_request();
        request_t r;
        int pick;
        r.value = {$urandom, $urandom};
        pick = $urandom_range(0, 3);
        if (pick == 0)
            r.value = 64'($signed($urandom_range(0, 2000)) - 1000);
        else if (pick == 1)
            r.value = r.value >> $urandom_range(0, 63);
        r.base = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(2, 36));
        r.min_digits = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 12));
        r.max_width = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
        r.min_width = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30));
        r.justify = 2'($urandom);
        r.sign_mode = 2'($urandom);
        r.upper_case = 1'($urandom);
        return r;
    endfunction

    function automatic request_t make_request(logic [63:0] v, int b, int md, int mxw,
                                              int mnw, int j, int s, int u);
        request_t r;
        r.value = v;
        r.base = 6'(b);
        r.min_digits = 7'(md);
        r.max_width = 8'(mxw);
        r.min_width = 8'(mnw);
        r.justify = 2'(j);
        r.sign_mode = 2'(s);
        r.upper_case = 1'(u);
        return r;
    endfunction

    initial
    begin
        int i;
        pending_requests.push_back(make_request(64'd0, 10, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(64'h8000_0000_0000_0000, 10, 0, 0, 0, 2, 0, 0));
        pending_requests.push_back(make_request(64'h7fff_ffff_ffff_ffff, 2, 0, 0, 0, 1, 1, 0));
        pending_requests.push_back(make_request('1, 2, 64, 0, 255, 3, 3, 1));
        pending_requests.push_back(make_request('1, 36, 0, 0, 0, 0, 0, 1));
        pending_requests.push_back(make_request(64'hdead_beef, 16, 0, 0, 20, 3, 2, 0));
        pending_requests.push_back(make_request(64'hdead_beef, 16, 0, 0, 20, 2, 1, 1));
        pending_requests.push_back(make_request(64'd1234, 0, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(64'd1234, 63, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(64'd5, 10, 127, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(64'd5, 10, 1, 1, 0, 0, 1, 0));
        pending_requests.push_back(make_request('1, 10, 1, 1, 3, 2, 0, 0));
        pending_requests.push_back(make_request(64'd5, 10, 4, 4, 0, 0, 2, 0));
        pending_requests.push_back(make_request(64'd123456, 10, 0, 4, 0, 0, 0, 0));
        pending_requests.push_back(make_request('1, 10, 0, 3, 9, 3, 0, 0));
        pending_requests.push_back(make_request(64'd42, 10, 0, 200, 1, 0, 1, 0));
        pending_requests.push_back(make_request(64'h8000_0000_0000_0000, 2, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(64'd7, 8, 64, 0, 0, 0, 1, 0));
        pending_requests.push_back(make_request(64'd7, 10, 0, 1, 0, 0, 1, 0));
        for (i = 0; i < 101; i++)
            pending_requests.push_back(random_request());
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        {value, base, min_digits, max_width, min_width, justify, sign_mode, upper_case} = '0;
        failures = 0;
        all_sent = 1'b0;
        gap = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(negedge clk)
    begin
        request_t r;
        if (rst_n) begin
            if (start && !busy_at_edge) begin
                start <= 1'b0;
                gap = $urandom_range(0, 8);
            end else if (!start) begin
                if (gap > 0)
                    gap--;
                else if (pending_requests.size() > 0 && !busy) begin
                    r = pending_requests.pop_front();
                    format_request(r);
                    value <= r.value;
                    base <= r.base;
                    min_digits <= r.min_digits;
                    max_width <= r.max_width;
                    min_width <= r.min_width;
                    justify <= r.justify;
                    sign_mode <= r.sign_mode;
                    upper_case <= r.upper_case;
                    start <= 1'b1;
                end else if (pending_requests.size() == 0)
                    all_sent = 1'b1;
            end
        end
    end

    always @(posedge clk)
        busy_at_edge <= busy;

    always @(posedge clk)
    begin
        word_t w;
        if (rst_n && out_valid) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: out_bytes %h", out_bytes);
                failures++;
            end else begin
                w = expected_words.pop_front();
                if (out_bytes !== w.chars) begin
                    $error("out_bytes expected %h actual %h", w.chars, out_bytes);
                    failures++;
                end
                if (byte_count !== w.count) begin
                    $error("byte_count expected %0d actual %0d", w.count, byte_count);
                    failures++;
                end
                if (total_chars !== w.total) begin
                    $error("total_chars expected %0d actual %0d", w.total, total_chars);
                    failures++;
                end
                if (last !== w.last) begin
                    $error("last expected %0d actual %0d", w.last, last);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        wait (all_sent && !start && expected_words.size() == 0);
        repeat (50) @(posedge clk);
        if (failures == 0 && expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
